// ===== rtl/pcbrc_pkg.sv =====
// Shared types, constants and codes for the per-class batch range cache.
`timescale 1ns / 1ps

package pcbrc_pkg;

    // Sizing
    localparam int NUM_CLASSES = 64;
    localparam int MAX_BATCHES = 64;

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int BAT_W  = $clog2(MAX_BATCHES);
    localparam int SLOT_W = CLS_W + BAT_W;

    // Field widths
    localparam int CLSIDX_W = 8;
    localparam int ADDR_W   = 48;
    localparam int CNT_W    = 12;
    localparam int HGT_W    = 7;
    localparam int TOT_W    = 18;
    localparam int CFG_W    = 8;
    localparam int CFGIDX_W = 2;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // Tier capacities, limited to the stack depth
    localparam int CAP0 = (64 < MAX_BATCHES) ? 64 : MAX_BATCHES;
    localparam int CAP1 = (32 < MAX_BATCHES) ? 32 : MAX_BATCHES;
    localparam int CAP2 = (16 < MAX_BATCHES) ? 16 : MAX_BATCHES;
    localparam int CAP3 = (8 < MAX_BATCHES) ? 8 : MAX_BATCHES;

    // Configuration register indexes
    localparam logic [CFGIDX_W-1:0] CFG_UPTO_64   = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_UPTO_256  = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_UPTO_1024 = 2'd2;

    typedef enum logic [1:0] {
        CMD_FETCH   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_DRAIN   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_FETCH_FWD = 3'd1,
        ST_STORED    = 3'd2,
        ST_REL_FWD   = 3'd3,
        ST_DRAINED   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_REJECT    = 3'd6
    } t_status;

    // One stored batch
    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [CNT_W-1:0]  count;
    } t_batch;

    // Per-class counters
    typedef struct packed {
        logic [HGT_W-1:0] height;
        logic [TOT_W-1:0] total;
    } t_class;

    // One result word
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  want;
        logic [HGT_W-1:0]  held_b;
        logic [TOT_W-1:0]  held_o;
        logic              final_r;
    } t_result;

endpackage

// ===== rtl/per_class_batch_range_cache_unit.sv =====
// Top level: command sequencer for the per-class batch stacks.
`timescale 1ns / 1ps

// Per-class batch range cache. Each size class holds a LIFO stack of batches
// (first address, last address, object count) and an object total; fetch pops,
// release pushes up to the class's tier capacity, drain emits every batch
// oldest first and clears the class. One word is handled at a time. Release,
// rejects and an empty drain go from accept to result through the class
// counter memory read, then decide and write back; a fetch hit adds a batch
// memory read after the counter read; a drain does one batch memory read per
// result. Output stalls can hold any of these steps. The result sits in an
// output register, so a new word is taken as soon as the previous one has
// finished. Counters come out of reset cleared through per-class valid bits;
// no clearing pass is needed.
module per_class_batch_range_cache_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [pcbrc_pkg::CFGIDX_W-1:0] i_cfg_index,
    input  logic [pcbrc_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [pcbrc_pkg::CLSIDX_W-1:0] i_class_index,
    input  logic [pcbrc_pkg::ADDR_W-1:0]  i_first_addr,
    input  logic [pcbrc_pkg::ADDR_W-1:0]  i_last_addr,
    input  logic [pcbrc_pkg::CNT_W-1:0]   i_batch_count,
    input  logic [pcbrc_pkg::CNT_W-1:0]   i_wanted_count,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_status,
    output logic [pcbrc_pkg::ADDR_W-1:0]  o_out_first,
    output logic [pcbrc_pkg::ADDR_W-1:0]  o_out_last,
    output logic [pcbrc_pkg::CNT_W-1:0]   o_out_count,
    output logic [pcbrc_pkg::CNT_W-1:0]   o_forward_wanted,
    output logic [pcbrc_pkg::HGT_W-1:0]   o_held_batches,
    output logic [pcbrc_pkg::TOT_W-1:0]   o_held_objects,
    output logic                          o_final_result
);
    import pcbrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_HIT   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [CFG_W-1:0] r_upto_64, r_upto_256, r_upto_1024;

    // Captured input word
    logic [1:0]          r_cmd;
    logic [CLSIDX_W-1:0] r_cls;
    logic [ADDR_W-1:0]   r_first, r_last;
    logic [CNT_W-1:0]    r_cnt, r_want;

    // Working counters
    logic [HGT_W-1:0] r_hgt, n_hgt;
    logic [TOT_W-1:0] r_tot, n_tot;
    logic [HGT_W-1:0] r_k, n_k;

    // Output register
    logic    r_out_valid;
    t_result r_res, n_res;
    logic    load_out;

    // Memory ports
    logic              cls_rd_en, cls_wr_en;
    logic [CLS_W-1:0]  cls_rd_addr, cls_wr_addr;
    t_class            cls_q, cls_wr_data;
    logic              bat_rd_en, bat_wr_en;
    logic [SLOT_W-1:0] bat_rd_addr, bat_wr_addr;
    t_batch            bat_q, bat_wr_data;

    logic              in_accept, out_free;
    logic              cls_bad;
    logic [HGT_W-1:0]  cap;
    logic [TOT_W:0]    sum_tot;
    logic [TOT_W-1:0]  sat_tot, sub_tot;
    logic [CLS_W-1:0]  cls_a;

    function automatic t_result mk_res(t_status st, t_batch b, logic [CNT_W-1:0] w,
                                       logic [HGT_W-1:0] hb, logic [TOT_W-1:0] ho,
                                       logic fin);
        t_result r;
        r.status  = st;
        r.first   = b.first;
        r.last    = b.last;
        r.count   = b.count;
        r.want    = w;
        r.held_b  = hb;
        r.held_o  = ho;
        r.final_r = fin;
        return r;
    endfunction

    pcbrc_class_ram u_class_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (cls_rd_en),
        .i_rd_addr (cls_rd_addr),
        .o_rd_data (cls_q),
        .i_wr_en   (cls_wr_en),
        .i_wr_addr (cls_wr_addr),
        .i_wr_data (cls_wr_data)
    );

    pcbrc_batch_ram u_batch_ram (
        .i_clk     (i_clk),
        .i_rd_en   (bat_rd_en),
        .i_rd_addr (bat_rd_addr),
        .o_rd_data (bat_q),
        .i_wr_en   (bat_wr_en),
        .i_wr_addr (bat_wr_addr),
        .i_wr_data (bat_wr_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign cls_a      = r_cls[CLS_W-1:0];
    assign cls_bad    = ({1'b0, r_cls} >= (CLSIDX_W + 1)'(NUM_CLASSES));

    // Tier capacity of the captured class
    always_comb begin
        if (r_cls <= r_upto_64) begin
            cap = HGT_W'(CAP0);
        end else if (r_cls <= r_upto_256) begin
            cap = HGT_W'(CAP1);
        end else if (r_cls <= r_upto_1024) begin
            cap = HGT_W'(CAP2);
        end else begin
            cap = HGT_W'(CAP3);
        end
    end

    // Saturating push total and clamped pop total
    assign sum_tot = {1'b0, cls_q.total} + (TOT_W + 1)'(r_cnt);
    assign sat_tot = sum_tot[TOT_W] ? TOTAL_MAX : sum_tot[TOT_W-1:0];
    assign sub_tot = (r_tot >= TOT_W'(bat_q.count)) ? (r_tot - TOT_W'(bat_q.count)) : '0;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_hgt       = r_hgt;
        n_tot       = r_tot;
        n_k         = r_k;
        cls_rd_en   = 1'b0;
        cls_rd_addr = i_class_index[CLS_W-1:0];
        cls_wr_en   = 1'b0;
        cls_wr_addr = cls_a;
        cls_wr_data = '0;
        bat_rd_en   = 1'b0;
        bat_rd_addr = {cls_a, BAT_W'(0)};
        bat_wr_en   = 1'b0;
        bat_wr_addr = {cls_a, cls_q.height[BAT_W-1:0]};
        bat_wr_data = '{first: r_first, last: r_last, count: r_cnt};
        load_out    = 1'b0;
        n_res       = mk_res(ST_REJECT, '0, '0, '0, '0, 1'b1);

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    cls_rd_en = 1'b1;
                    n_state   = S_LOOK;
                end
            end
            S_LOOK: begin
                if (cls_bad) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    case (r_cmd)
                        CMD_FETCH: begin
                            if (r_want == '0) begin
                                n_res = mk_res(ST_REJECT, '0, '0, cls_q.height,
                                               cls_q.total, 1'b1);
                                if (out_free) begin
                                    load_out = 1'b1;
                                    n_state  = S_IDLE;
                                end
                            end else if (cls_q.height == '0) begin
                                n_res = mk_res(ST_FETCH_FWD, '0, r_want, '0,
                                               cls_q.total, 1'b1);
                                if (out_free) begin
                                    load_out = 1'b1;
                                    n_state  = S_IDLE;
                                end
                            end else begin
                                // pop: read the top slot
                                n_hgt       = cls_q.height - 1'b1;
                                n_tot       = cls_q.total;
                                bat_rd_en   = 1'b1;
                                bat_rd_addr = {cls_a, n_hgt[BAT_W-1:0]};
                                n_state     = S_HIT;
                            end
                        end
                        CMD_RELEASE: begin
                            if (r_first == '0 || r_last == '0 || r_cnt == '0) begin
                                n_res = mk_res(ST_REJECT, '0, '0, cls_q.height,
                                               cls_q.total, 1'b1);
                            end else if (cls_q.height < cap) begin
                                n_res = mk_res(ST_STORED, '0, '0, cls_q.height + 1'b1,
                                               sat_tot, 1'b1);
                                if (out_free) begin
                                    bat_wr_en   = 1'b1;
                                    cls_wr_en   = 1'b1;
                                    cls_wr_data = '{height: cls_q.height + 1'b1,
                                                    total: sat_tot};
                                end
                            end else begin
                                n_res = mk_res(ST_REL_FWD, bat_wr_data, '0,
                                               cls_q.height, cls_q.total, 1'b1);
                            end
                            if (out_free) begin
                                load_out = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        CMD_DRAIN: begin
                            if (cls_q.height == '0) begin
                                n_res = mk_res(ST_EMPTY, '0, '0, '0, '0, 1'b1);
                                if (out_free) begin
                                    load_out = 1'b1;
                                    n_state  = S_IDLE;
                                end
                            end else begin
                                // clear the class now, then walk the slots
                                cls_wr_en   = 1'b1;
                                n_hgt       = cls_q.height;
                                n_k         = '0;
                                bat_rd_en   = 1'b1;
                                bat_rd_addr = {cls_a, BAT_W'(0)};
                                n_state     = S_DRAIN;
                            end
                        end
                        default: begin
                            n_res = mk_res(ST_REJECT, '0, '0, cls_q.height,
                                           cls_q.total, 1'b1);
                            if (out_free) begin
                                load_out = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_HIT: begin
                n_res = mk_res(ST_HIT, bat_q, '0, r_hgt, sub_tot, 1'b1);
                if (out_free) begin
                    cls_wr_en   = 1'b1;
                    cls_wr_data = '{height: r_hgt, total: sub_tot};
                    load_out    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DRAIN: begin
                n_res = mk_res(ST_DRAINED, bat_q, '0, '0, '0, (r_k + 1'b1) == r_hgt);
                if (out_free) begin
                    load_out = 1'b1;
                    if ((r_k + 1'b1) == r_hgt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k         = r_k + 1'b1;
                        bat_rd_en   = 1'b1;
                        bat_rd_addr = {cls_a, n_k[BAT_W-1:0]};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_upto_64   <= CFG_W'(7);
            r_upto_256  <= CFG_W'(15);
            r_upto_1024 <= CFG_W'(31);
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UPTO_64:   r_upto_64   <= i_cfg_data;
                    CFG_UPTO_256:  r_upto_256  <= i_cfg_data;
                    CFG_UPTO_1024: r_upto_1024 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_cmd;
            r_cls   <= i_class_index;
            r_first <= i_first_addr;
            r_last  <= i_last_addr;
            r_cnt   <= i_batch_count;
            r_want  <= i_wanted_count;
        end
        r_hgt <= n_hgt;
        r_tot <= n_tot;
        r_k   <= n_k;
        if (load_out) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_res.status;
    assign o_out_first      = r_res.first;
    assign o_out_last       = r_res.last;
    assign o_out_count      = r_res.count;
    assign o_forward_wanted = r_res.want;
    assign o_held_batches   = r_res.held_b;
    assign o_held_objects   = r_res.held_o;
    assign o_final_result   = r_res.final_r;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // Counter read and write never collide on the same edge
    a_cls_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cls_rd_en && cls_wr_en))
        else $error("class memory read and write in same cycle");

    // Drain index stays below the captured height
    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_k < r_hgt))
        else $error("drain index past stack height");

    // The last result of a word returns the sequencer to idle
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_res.final_r) |=> (r_state == S_IDLE))
        else $error("final result without return to idle");

    // An accepted word is looked up in the next cycle
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_LOOK))
        else $error("accepted word not looked up");

endmodule

// ===== rtl/pcbrc_class_ram.sv =====
// Per-class counter memory with reset-cleared valid bits and registered read.
`timescale 1ns / 1ps

module pcbrc_class_ram (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [pcbrc_pkg::CLS_W-1:0] i_rd_addr,
    output pcbrc_pkg::t_class      o_rd_data,
    input  logic                   i_wr_en,
    input  logic [pcbrc_pkg::CLS_W-1:0] i_wr_addr,
    input  pcbrc_pkg::t_class      i_wr_data
);
    import pcbrc_pkg::*;

    t_class                 r_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_valid;
    t_class                 r_rd_data;

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Storage and registered read; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pcbrc_batch_ram.sv =====
// Batch slot memory: one write and one registered read port.
`timescale 1ns / 1ps

module pcbrc_batch_ram (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [pcbrc_pkg::SLOT_W-1:0] i_rd_addr,
    output pcbrc_pkg::t_batch       o_rd_data,
    input  logic                    i_wr_en,
    input  logic [pcbrc_pkg::SLOT_W-1:0] i_wr_addr,
    input  pcbrc_pkg::t_batch       i_wr_data
);
    import pcbrc_pkg::*;

    localparam int DEPTH = 1 << SLOT_W;

    t_batch r_mem [DEPTH];
    t_batch r_rd_data;

    // Contents are undefined until written; only written slots are read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the per-class batch range cache, checked against a shadow model.
`timescale 1ns / 1ps

module tb_top;
    import pcbrc_pkg::*;

    // Command code with no operation behind it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]          cmd;
        logic [CLSIDX_W-1:0] cls;
        logic [ADDR_W-1:0]   first;
        logic [ADDR_W-1:0]   last;
        logic [CNT_W-1:0]    cnt;
        logic [CNT_W-1:0]    want;
    } t_cache_word;

    // Clock and DUT ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFGIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_cmd = '0;
    logic [CLSIDX_W-1:0] i_class_index = '0;
    logic [ADDR_W-1:0]   i_first_addr = '0;
    logic [ADDR_W-1:0]   i_last_addr = '0;
    logic [CNT_W-1:0]    i_batch_count = '0;
    logic [CNT_W-1:0]    i_wanted_count = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [2:0]          o_status;
    logic [ADDR_W-1:0]   o_out_first;
    logic [ADDR_W-1:0]   o_out_last;
    logic [CNT_W-1:0]    o_out_count;
    logic [CNT_W-1:0]    o_forward_wanted;
    logic [HGT_W-1:0]    o_held_batches;
    logic [TOT_W-1:0]    o_held_objects;
    logic                o_final_result;

    always #10 i_clk = ~i_clk;

    per_class_batch_range_cache_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_class_index    (i_class_index),
        .i_first_addr     (i_first_addr),
        .i_last_addr      (i_last_addr),
        .i_batch_count    (i_batch_count),
        .i_wanted_count   (i_wanted_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_out_first      (o_out_first),
        .o_out_last       (o_out_last),
        .o_out_count      (o_out_count),
        .o_forward_wanted (o_forward_wanted),
        .o_held_batches   (o_held_batches),
        .o_held_objects   (o_held_objects),
        .o_final_result   (o_final_result)
    );

    // Shadow copy of the cache state and thresholds
    logic [ADDR_W-1:0] shadow_first [NUM_CLASSES*MAX_BATCHES];
    logic [ADDR_W-1:0] shadow_last  [NUM_CLASSES*MAX_BATCHES];
    logic [CNT_W-1:0]  shadow_cnt   [NUM_CLASSES*MAX_BATCHES];
    int                shadow_height [NUM_CLASSES];
    int                shadow_total  [NUM_CLASSES];
    logic [CFG_W-1:0]  thr_upto_64   = 8'd7;
    logic [CFG_W-1:0]  thr_upto_256  = 8'd15;
    logic [CFG_W-1:0]  thr_upto_1024 = 8'd31;

    t_cache_word pending_words [$];
    t_result     batch_results_due [$];

    int  words_queued = 0;
    int  words_taken = 0;
    int  results_seen = 0;
    int  err_count = 0;
    int  status_tally [8];
    int  send_idle_pct = 22;
    int  recv_idle_pct = 79;
    int  hold_left = 0;
    bit  in_taken = 1'b0;

    initial begin
        foreach (shadow_height[c]) begin
            shadow_height[c] = 0;
            shadow_total[c] = 0;
        end
        foreach (status_tally[s]) status_tally[s] = 0;
    end

    // Batch slots a class may hold under the current thresholds
    function automatic int class_capacity(int c);
        int cap;
        if (c <= int'(thr_upto_64)) cap = 64;
        else if (c <= int'(thr_upto_256)) cap = 32;
        else if (c <= int'(thr_upto_1024)) cap = 16;
        else cap = 8;
        return (cap < MAX_BATCHES) ? cap : MAX_BATCHES;
    endfunction

    // Append one expected result word
    function automatic void add_expected(t_result r);
        batch_results_due = {batch_results_due, r};
    endfunction

    // Apply one accepted word to the shadow state and queue the words it returns
    function automatic void predict_batch_results(t_cache_word w);
        t_result r;
        int c, h, slot, n, t, k;
        c = int'(w.cls);
        r = '0;
        r.status = ST_REJECT;
        r.final_r = 1'b1;
        if (c >= NUM_CLASSES) begin
            add_expected(r);
            return;
        end
        h = shadow_height[c];
        r.held_b = HGT_W'(h);
        r.held_o = TOT_W'(shadow_total[c]);
        case (w.cmd)
            CMD_FETCH: begin
                if (w.want == 0) begin
                    // zero wanted count: reject
                end else if (h == 0) begin
                    r.status = ST_FETCH_FWD;
                    r.want = w.want;
                end else begin
                    h = h - 1;
                    slot = c * MAX_BATCHES + h;
                    n = int'(shadow_cnt[slot]);
                    shadow_total[c] = (shadow_total[c] >= n) ? shadow_total[c] - n : 0;
                    shadow_height[c] = h;
                    r.status = ST_HIT;
                    r.first = shadow_first[slot];
                    r.last = shadow_last[slot];
                    r.count = CNT_W'(n);
                    r.held_b = HGT_W'(h);
                    r.held_o = TOT_W'(shadow_total[c]);
                end
                add_expected(r);
            end
            CMD_RELEASE: begin
                if (w.first == 0 || w.last == 0 || w.cnt == 0) begin
                    // null or empty batch: reject, state untouched
                end else if (h < class_capacity(c)) begin
                    slot = c * MAX_BATCHES + h;
                    shadow_first[slot] = w.first;
                    shadow_last[slot] = w.last;
                    shadow_cnt[slot] = w.cnt;
                    shadow_height[c] = h + 1;
                    t = shadow_total[c] + int'(w.cnt);
                    shadow_total[c] = (t > int'(TOTAL_MAX)) ? int'(TOTAL_MAX) : t;
                    r.status = ST_STORED;
                    r.held_b = HGT_W'(h + 1);
                    r.held_o = TOT_W'(shadow_total[c]);
                end else begin
                    r.status = ST_REL_FWD;
                    r.first = w.first;
                    r.last = w.last;
                    r.count = w.cnt;
                end
                add_expected(r);
            end
            CMD_DRAIN: begin
                if (h > MAX_BATCHES) h = MAX_BATCHES;
                shadow_height[c] = 0;
                shadow_total[c] = 0;
                r.held_b = '0;
                r.held_o = '0;
                if (h == 0) begin
                    r.status = ST_EMPTY;
                    add_expected(r);
                end else begin
                    // oldest batch first, last one flagged
                    for (k = 0; k < h; k++) begin
                        slot = c * MAX_BATCHES + k;
                        r.status = ST_DRAINED;
                        r.first = shadow_first[slot];
                        r.last = shadow_last[slot];
                        r.count = shadow_cnt[slot];
                        r.final_r = (k == h - 1);
                        add_expected(r);
                    end
                end
            end
            default: add_expected(r);
        endcase
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Input driver: present a new word once the previous one is taken
    always @(negedge i_clk) begin
        t_cache_word w;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                i_in_valid <= 1'b1;
                i_cmd <= w.cmd;
                i_class_index <= w.cls;
                i_first_addr <= w.first;
                i_last_addr <= w.last;
                i_batch_count <= w.cnt;
                i_wanted_count <= w.want;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready: random backpressure, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: track config writes, predict on accept, check returned words
    always @(posedge i_clk) begin
        t_cache_word w;
        t_result exp_r;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UPTO_64:   thr_upto_64 = i_cfg_data;
                    CFG_UPTO_256:  thr_upto_256 = i_cfg_data;
                    CFG_UPTO_1024: thr_upto_1024 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                words_taken++;
                w.cmd = i_cmd;
                w.cls = i_class_index;
                w.first = i_first_addr;
                w.last = i_last_addr;
                w.cnt = i_batch_count;
                w.want = i_wanted_count;
                predict_batch_results(w);
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                status_tally[o_status]++;
                if (batch_results_due.size() == 0) begin
                    $error("result word with nothing pending, status %0d", o_status);
                    err_count++;
                end else begin
                    exp_r = batch_results_due.pop_front();
                    compare_field("status", exp_r.status, o_status);
                    compare_field("out_first", exp_r.first, o_out_first);
                    compare_field("out_last", exp_r.last, o_out_last);
                    compare_field("out_count", exp_r.count, o_out_count);
                    compare_field("forward_wanted", exp_r.want, o_forward_wanted);
                    compare_field("held_batches", exp_r.held_b, o_held_batches);
                    compare_field("held_objects", exp_r.held_o, o_held_objects);
                    compare_field("final_result", exp_r.final_r, o_final_result);
                end
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic queue_word(logic [1:0] cmd, logic [CLSIDX_W-1:0] cls,
                              logic [ADDR_W-1:0] first, logic [ADDR_W-1:0] last,
                              logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] want);
        t_cache_word w;
        w.cmd = cmd;
        w.cls = cls;
        w.first = first;
        w.last = last;
        w.cnt = cnt;
        w.want = want;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    task automatic queue_good_release(int cls);
        queue_word(CMD_RELEASE, CLSIDX_W'(cls), rand_addr(), rand_addr(),
                   CNT_W'($urandom_range(1, 4095)), CNT_W'($urandom));
    endtask

    // Wait until every word is taken and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (words_taken != words_queued || batch_results_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_thresholds(logic [CFG_W-1:0] t64, logic [CFG_W-1:0] t256,
                                  logic [CFG_W-1:0] t1024);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_UPTO_64;
        i_cfg_data <= t64;
        @(negedge i_clk);
        i_cfg_index <= CFG_UPTO_256;
        i_cfg_data <= t256;
        @(negedge i_clk);
        i_cfg_index <= CFG_UPTO_1024;
        i_cfg_data <= t1024;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Fill a hot class past its capacity, then a random mix around it
    task automatic queue_random_phase(int hot_cls, int fill, int n_words);
        int i, roll, cls, pick;
        logic [ADDR_W-1:0] fa, la;
        logic [CNT_W-1:0] bc;
        for (i = 0; i < fill; i++) queue_good_release(hot_cls);
        queue_word(CMD_FETCH, CLSIDX_W'(hot_cls), rand_addr(), rand_addr(),
                   CNT_W'($urandom), CNT_W'($urandom_range(1, 4095)));
        for (i = 0; i < n_words; i++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            if (pick < 7) cls = hot_cls + $urandom_range(0, 3);
            else cls = $urandom_range(0, NUM_CLASSES - 1);
            if (cls >= NUM_CLASSES) cls = $urandom_range(0, NUM_CLASSES - 1);
            if (roll < 50) begin
                queue_good_release(cls);
            end else if (roll < 80) begin
                queue_word(CMD_FETCH, CLSIDX_W'(cls), rand_addr(), rand_addr(),
                           CNT_W'($urandom), CNT_W'($urandom_range(1, 4095)));
            end else if (roll < 85) begin
                queue_word(CMD_DRAIN, CLSIDX_W'(cls), rand_addr(), rand_addr(),
                           CNT_W'($urandom), CNT_W'($urandom));
            end else if (roll < 90) begin
                // broken release: one of the fields null
                fa = rand_addr();
                la = rand_addr();
                bc = CNT_W'($urandom);
                case ($urandom_range(0, 2))
                    0: fa = '0;
                    1: la = '0;
                    default: bc = '0;
                endcase
                queue_word(CMD_RELEASE, CLSIDX_W'(cls), fa, la, bc, CNT_W'($urandom));
            end else if (roll < 93) begin
                queue_word(CMD_FETCH, CLSIDX_W'(cls), rand_addr(), rand_addr(),
                           CNT_W'($urandom), '0);
            end else if (roll < 96) begin
                queue_word(CMD_UNUSED, CLSIDX_W'(cls), rand_addr(), rand_addr(),
                           CNT_W'($urandom), CNT_W'($urandom));
            end else begin
                queue_word(2'($urandom), CLSIDX_W'($urandom_range(NUM_CLASSES, 255)),
                           rand_addr(), rand_addr(), CNT_W'($urandom), CNT_W'($urandom));
            end
        end
        queue_word(CMD_DRAIN, CLSIDX_W'(hot_cls), '0, '0, '0, '0);
    endtask

    // Main sequence
    initial begin
        int i;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset thresholds
        queue_word(CMD_FETCH, 0, '0, '0, '0, 12'hFFF);
        queue_word(CMD_FETCH, 0, '0, '0, '0, '0);
        queue_word(CMD_RELEASE, 0, '0, 48'h1234, 12'd5, '0);
        queue_word(CMD_RELEASE, 0, 48'h1234, '0, 12'd5, '0);
        queue_word(CMD_RELEASE, 0, 48'h1234, 48'h5678, '0, '0);
        queue_word(CMD_RELEASE, 0, '1, '1, '1, '1);
        queue_word(CMD_RELEASE, 0, 48'd1, 48'd1, 12'd1, '0);
        queue_word(CMD_FETCH, 0, '0, '0, '0, 12'd1);
        queue_word(CMD_FETCH, 0, '0, '0, '0, 12'd7);
        queue_word(CMD_FETCH, 0, '0, '0, '0, 12'd7);
        queue_word(CMD_FETCH, 8'd255, '1, '1, '1, '1);
        queue_word(CMD_RELEASE, CLSIDX_W'(NUM_CLASSES), 48'h10, 48'h20, 12'd3, '0);
        queue_word(CMD_UNUSED, 1, '0, '0, '0, 12'd1);
        queue_word(CMD_DRAIN, 2, '0, '0, '0, '0);
        // class 40 sits in the smallest tier; the ninth release overflows it
        for (i = 0; i < 9; i++) queue_good_release(40);
        queue_word(CMD_DRAIN, 40, '0, '0, '0, '0);
        queue_word(CMD_UNUSED, 8'd200, '0, '0, '0, '0);
        wait_idle();

        @(posedge i_clk);
        queue_random_phase(20, 18, 60);
        wait_idle();

        set_thresholds(8'd0, 8'd0, 8'd0);
        queue_random_phase(1, 10, 45);
        wait_idle();

        set_thresholds(8'd255, 8'd255, 8'd255);
        send_idle_pct = 79;
        recv_idle_pct = 22;
        queue_random_phase(5, 66, 40);
        wait_idle();

        set_thresholds(8'd10, 8'd40, 8'd60);
        queue_random_phase(30, 34, 50);
        wait_idle();

        // No idling; receiver holds off long enough to back up the input
        set_thresholds(8'd3, 8'd3, 8'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 300;
        queue_random_phase(60, 10, 45);
        wait_idle();

        repeat (80) @(negedge i_clk);
        $display("tb_top: %0d words in, %0d words out, over five threshold settings",
                 words_taken, results_seen);
        $display("tb_top: hit %0d, fwd %0d, stored %0d, rel fwd %0d, drained %0d, rej %0d",
                 status_tally[ST_HIT], status_tally[ST_FETCH_FWD],
                 status_tally[ST_STORED], status_tally[ST_REL_FWD],
                 status_tally[ST_DRAINED], status_tally[ST_REJECT]);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
